// File: hdl/aiir_pkg.sv
// Shared types and constants for the ARMA IIR filter unit.
// Used by every module of the block; depends on nothing else.
`timescale 1ns / 1ps

package aiir_pkg;

  // Number of coefficient registers per branch (moving average and autoregressive).
  localparam int unsigned LAG_MAX     = 4;
  localparam int unsigned NUM_REGS    = 2 * LAG_MAX;
  localparam int unsigned MA_LAGS_DEF = 4;
  localparam int unsigned AR_LAGS_DEF = 4;
  localparam int unsigned QDEPTH_DEF  = 4;

  localparam int unsigned SAMPLE_W = 16;
  localparam int unsigned COEF_W   = 18;
  localparam int unsigned PROD_W   = SAMPLE_W + COEF_W;
  // Sum of up to LAG_MAX products, and of the autoregressive products past lag one.
  localparam int unsigned MA_SUM_W = PROD_W + 2;
  localparam int unsigned PART_W   = PROD_W + 2;
  // Full accumulator: up to 2 * LAG_MAX products.
  localparam int unsigned ACC_W    = PROD_W + 3;
  localparam int unsigned FRAC_SH  = 16;
  localparam int unsigned RES_W    = ACC_W - FRAC_SH;

  localparam int unsigned APB_AW = 5;
  localparam int unsigned APB_DW = 32;

  typedef logic signed [SAMPLE_W-1:0] sample_t;
  typedef logic signed [COEF_W-1:0]   coef_t;
  typedef logic signed [PROD_W-1:0]   prod_t;

  // One entry of the queue between the front and the back.
  typedef struct packed {
    logic signed [MA_SUM_W-1:0] ma_sum;
    logic                       restart;
  } ma_item_t;

endpackage

// File: hdl/aiir_fifo.sv
// Small register-based queue carrying moving-average sums from front to back.
// Depends on aiir_pkg for the entry type.
`timescale 1ns / 1ps

module aiir_fifo import aiir_pkg::*; #(
  parameter int unsigned DEPTH = QDEPTH_DEF
) (
  input  logic     clk_i,
  input  logic     rst_ni,
  input  logic     push_i,
  input  ma_item_t push_item_i,
  output logic     head_valid_o,
  output ma_item_t head_item_o,
  input  logic     pop_i
);

  localparam int unsigned PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int unsigned CNT_W = $clog2(DEPTH + 1);

  ma_item_t          mem_q [DEPTH];
  logic [PTR_W-1:0]  wr_ptr_q, wr_ptr_d;
  logic [PTR_W-1:0]  rd_ptr_q, rd_ptr_d;
  logic [CNT_W-1:0]  count_q, count_d;
  logic              do_push, do_pop;

  assign do_pop  = pop_i && (count_q != '0);
  assign do_push = push_i && ((count_q != CNT_W'(DEPTH)) || do_pop);

  assign head_valid_o = (count_q != '0);
  assign head_item_o  = mem_q[rd_ptr_q];

  always_comb begin
    wr_ptr_d = wr_ptr_q;
    rd_ptr_d = rd_ptr_q;
    count_d  = count_q;
    if (do_push) begin
      wr_ptr_d = (wr_ptr_q == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_q + 1'b1;
    end
    if (do_pop) begin
      rd_ptr_d = (rd_ptr_q == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_q + 1'b1;
    end
    if (do_push && !do_pop) begin
      count_d = count_q + 1'b1;
    end else if (do_pop && !do_push) begin
      count_d = count_q - 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      count_q  <= count_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (do_push) begin
      mem_q[wr_ptr_q] <= push_item_i;
    end
  end

endmodule

// File: hdl/aiir_front.sv
// Front part: accepts input items, keeps the input history and forms the
// moving-average sum in two registered stages. Depends on aiir_pkg.
`timescale 1ns / 1ps

module aiir_front import aiir_pkg::*; #(
  parameter int unsigned MA_LAGS = MA_LAGS_DEF,
  parameter int unsigned QDEPTH  = QDEPTH_DEF
) (
  input  logic                   clk_i,
  input  logic                   rst_ni,
  input  logic                   in_valid_i,
  output logic                   in_ready_o,
  input  sample_t                sample_i,
  input  logic                   restart_i,
  input  coef_t [LAG_MAX-1:0]    ma_coef_i,
  input  logic                   pop_i,
  output logic                   push_o,
  output ma_item_t               push_item_o
);

  localparam int unsigned OCC_W = $clog2(QDEPTH + 1);

  sample_t                    x_hist_q [MA_LAGS];
  prod_t                      prod_q   [MA_LAGS];
  prod_t                      prod_d   [MA_LAGS];
  logic                       v1_q, v2_q;
  logic                       rst1_q, rst2_q;
  logic signed [MA_SUM_W-1:0] sum_q, sum_d;
  logic [OCC_W-1:0]           occ_q, occ_d;
  logic                       accept;

  // Items in flight in the two stages plus those in the queue never exceed
  // the queue depth, so the queue cannot overflow and the stages never stall.
  assign in_ready_o = (occ_q < OCC_W'(QDEPTH));
  assign accept     = in_valid_i && in_ready_o;

  always_comb begin
    occ_d = occ_q;
    if (accept && !pop_i) begin
      occ_d = occ_q + 1'b1;
    end else if (pop_i && !accept) begin
      occ_d = occ_q - 1'b1;
    end
  end

  // A restart item sees an all-zero history, so its products are zero.
  always_comb begin
    for (int k = 0; k < MA_LAGS; k++) begin
      prod_d[k] = '0;
      if (!restart_i) begin
        prod_d[k] = ma_coef_i[k] * x_hist_q[k];
      end
    end
  end

  always_comb begin
    sum_d = '0;
    for (int k = 0; k < MA_LAGS; k++) begin
      sum_d = sum_d + MA_SUM_W'(prod_q[k]);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      occ_q <= '0;
      v1_q  <= 1'b0;
      v2_q  <= 1'b0;
      for (int k = 0; k < MA_LAGS; k++) begin
        x_hist_q[k] <= '0;
      end
    end else begin
      occ_q <= occ_d;
      v1_q  <= accept;
      v2_q  <= v1_q;
      if (accept) begin
        x_hist_q[0] <= sample_i;
        for (int k = 1; k < MA_LAGS; k++) begin
          x_hist_q[k] <= restart_i ? '0 : x_hist_q[k-1];
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      prod_q <= prod_d;
      rst1_q <= restart_i;
    end
    if (v1_q) begin
      sum_q  <= sum_d;
      rst2_q <= rst1_q;
    end
  end

  assign push_o              = v2_q;
  assign push_item_o.ma_sum  = sum_q;
  assign push_item_o.restart = rst2_q;

endmodule

// File: hdl/aiir_back.sv
// Back part: closes the autoregressive feedback loop, rounds and saturates,
// and holds the result in the output register. Depends on aiir_pkg.
`timescale 1ns / 1ps

module aiir_back import aiir_pkg::*; #(
  parameter int unsigned AR_LAGS = AR_LAGS_DEF
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                head_valid_i,
  input  ma_item_t            head_item_i,
  output logic                pop_o,
  input  coef_t [LAG_MAX-1:0] ar_coef_i,
  output logic                out_valid_o,
  input  logic                out_ready_i,
  output sample_t             out_sample_o,
  output logic                out_sat_o
);

  localparam sample_t SAT_MAX = sample_t'({1'b0, {(SAMPLE_W-1){1'b1}}});
  localparam sample_t SAT_MIN = sample_t'({1'b1, {(SAMPLE_W-1){1'b0}}});

  sample_t                  y_hist_q [AR_LAGS];
  logic signed [PART_W-1:0] part_q, part_d;
  prod_t                    lag1_prod;
  prod_t                    part_prod;
  sample_t                  next_y;
  logic signed [ACC_W-1:0]  acc;
  logic signed [ACC_W-1:0]  acc_rnd;
  logic signed [RES_W-1:0]  res;
  logic                     sat;
  sample_t                  y_new;
  logic                     out_valid_q;
  sample_t                  out_sample_q;
  logic                     out_sat_q;

  assign pop_o = head_valid_i && (!out_valid_q || out_ready_i);

  // Lag-one term is the only product inside the output feedback loop.
  always_comb begin
    lag1_prod = '0;
    if (!head_item_i.restart) begin
      lag1_prod = ar_coef_i[0] * y_hist_q[0];
    end
  end

  always_comb begin
    acc = ACC_W'(head_item_i.ma_sum) - ACC_W'(lag1_prod);
    if (!head_item_i.restart) begin
      acc = acc - ACC_W'(part_q);
    end
    acc_rnd = acc + ACC_W'(1 << (FRAC_SH - 1));
    res     = acc_rnd[ACC_W-1:FRAC_SH];
    sat     = !((&res[RES_W-1:SAMPLE_W-1]) || !(|res[RES_W-1:SAMPLE_W-1]));
    if (sat) begin
      y_new = res[RES_W-1] ? SAT_MIN : SAT_MAX;
    end else begin
      y_new = res[SAMPLE_W-1:0];
    end
  end

  // Terms for lags two and up are registered ahead in part_q, formed from the
  // history in place at the next edge; it does not depend on y_new.
  always_comb begin
    part_d    = '0;
    part_prod = '0;
    next_y    = '0;
    for (int k = 1; k < AR_LAGS; k++) begin
      if (pop_o) begin
        next_y = head_item_i.restart ? '0 : y_hist_q[k-1];
      end else begin
        next_y = y_hist_q[k];
      end
      part_prod = ar_coef_i[k] * next_y;
      part_d    = part_d + PART_W'(part_prod);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      part_q      <= '0;
      out_valid_q <= 1'b0;
      for (int k = 0; k < AR_LAGS; k++) begin
        y_hist_q[k] <= '0;
      end
    end else begin
      part_q <= part_d;
      if (pop_o) begin
        out_valid_q <= 1'b1;
        y_hist_q[0] <= y_new;
        for (int k = 1; k < AR_LAGS; k++) begin
          y_hist_q[k] <= head_item_i.restart ? '0 : y_hist_q[k-1];
        end
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (pop_o) begin
      out_sample_q <= y_new;
      out_sat_q    <= sat;
    end
  end

  assign out_valid_o  = out_valid_q;
  assign out_sample_o = out_sample_q;
  assign out_sat_o    = out_sat_q;

endmodule

// File: hdl/arma_iir_filter_unit.sv
// Top level of the streaming ARMA (IIR) filter unit with its register port.
// Depends on aiir_pkg, aiir_front, aiir_fifo and aiir_back.
`timescale 1ns / 1ps

// The unit filters a stream of signed Q1.15 samples. Each item accepted on
// the slave stream (s_axis_*) yields exactly one item on the master stream
// (m_axis_*), in order. The output is the sum of the moving-average
// coefficients times the inputs at lags one and up, minus the sum of the
// autoregressive coefficients times the outputs at lags one and up, rounded
// to nearest and saturated to 16 bits; tuser on the output flags saturation.
// Setting tuser on an input item restarts the sequence: both histories are
// taken as zero for that item, whose output is therefore zero.
// The eight Q2.16 coefficients are written through the APB port at byte
// addresses 0 to 28, moving average first; the user must see that they are
// written only while idle, since the unit does not enforce it. Throughput
// is one item per cycle while the receiver keeps taking items. The
// moving-average products take two registered stages in the front, then a
// four-entry queue, then the output register in the back, where the lag-one
// feedback multiply, rounding and saturation close the loop from one output
// to the next. When the receiver stalls, results pile up in the queue and
// s_axis_tready drops once the queue and the front stages hold four items.
// Reset clears the coefficients, both histories and all valid state.
module arma_iir_filter_unit import aiir_pkg::*; #(
  parameter int unsigned MA_LAGS     = MA_LAGS_DEF,
  parameter int unsigned AR_LAGS     = AR_LAGS_DEF,
  parameter int unsigned QUEUE_DEPTH = QDEPTH_DEF
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  // Input stream.
  input  logic              s_axis_tvalid,
  output logic              s_axis_tready,
  input  logic [15:0]       s_axis_tdata,   // [15:0] sample_in
  input  logic [0:0]        s_axis_tuser,   // [0] restart
  // Output stream.
  output logic              m_axis_tvalid,
  input  logic              m_axis_tready,
  output logic [15:0]       m_axis_tdata,   // [15:0] sample_out
  output logic [0:0]        m_axis_tuser,   // [0] saturated
  // Register port.
  input  logic              psel,
  input  logic              penable,
  input  logic              pwrite,
  input  logic [APB_AW-1:0] paddr,
  input  logic [APB_DW-1:0] pwdata,
  output logic [APB_DW-1:0] prdata,
  output logic              pready
);

  coef_t [NUM_REGS-1:0] coef_q;
  logic [2:0]           reg_idx;
  logic                 reg_wr;
  coef_t [LAG_MAX-1:0]  ma_coef;
  coef_t [LAG_MAX-1:0]  ar_coef;
  logic                 fifo_push;
  ma_item_t             fifo_push_item;
  logic                 fifo_head_valid;
  ma_item_t             fifo_head_item;
  logic                 fifo_pop;
  sample_t              out_sample;
  logic                 out_sat;

  // Coefficient registers: one per word, index taken from the word address.
  assign pready  = 1'b1;
  assign reg_idx = paddr[APB_AW-1:2];
  assign reg_wr  = psel && penable && pwrite && pready;
  assign prdata  = APB_DW'(coef_q[reg_idx]);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      coef_q <= '0;
    end else if (reg_wr) begin
      coef_q[reg_idx] <= pwdata[COEF_W-1:0];
    end
  end

  assign ma_coef = coef_q[LAG_MAX-1:0];
  assign ar_coef = coef_q[NUM_REGS-1:LAG_MAX];

  aiir_front #(
    .MA_LAGS (MA_LAGS),
    .QDEPTH  (QUEUE_DEPTH)
  ) u_front (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (s_axis_tvalid),
    .in_ready_o  (s_axis_tready),
    .sample_i    (s_axis_tdata),
    .restart_i   (s_axis_tuser[0]),
    .ma_coef_i   (ma_coef),
    .pop_i       (fifo_pop),
    .push_o      (fifo_push),
    .push_item_o (fifo_push_item)
  );

  aiir_fifo #(
    .DEPTH (QUEUE_DEPTH)
  ) u_fifo (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .push_i       (fifo_push),
    .push_item_i  (fifo_push_item),
    .head_valid_o (fifo_head_valid),
    .head_item_o  (fifo_head_item),
    .pop_i        (fifo_pop)
  );

  aiir_back #(
    .AR_LAGS (AR_LAGS)
  ) u_back (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .head_valid_i (fifo_head_valid),
    .head_item_i  (fifo_head_item),
    .pop_o        (fifo_pop),
    .ar_coef_i    (ar_coef),
    .out_valid_o  (m_axis_tvalid),
    .out_ready_i  (m_axis_tready),
    .out_sample_o (out_sample),
    .out_sat_o    (out_sat)
  );

  assign m_axis_tdata    = out_sample;
  assign m_axis_tuser[0] = out_sat;

endmodule

// File: verif/arma_iir_filter_unit_tb.sv
// Self-checking testbench for the ARMA IIR filter unit.
// Depends on aiir_pkg and arma_iir_filter_unit; predicts every output sample locally.
`timescale 1ns / 1ps

// The bench writes coefficients through the APB port only while the filter
// is idle. It streams samples in with random gaps and random output stalls.
// Each accepted sample is run through a local fixed-point filter model, and
// the predicted output is queued. Every output item is compared with the
// oldest prediction. A watchdog ends the run if nothing moves for too long.
module arma_iir_filter_unit_tb;
  import aiir_pkg::*;

  localparam int unsigned MA_N         = (MA_LAGS_DEF > LAG_MAX) ? LAG_MAX : MA_LAGS_DEF;
  localparam int unsigned AR_N         = (AR_LAGS_DEF > LAG_MAX) ? LAG_MAX : AR_LAGS_DEF;
  localparam int unsigned REG_MA_BASE  = 0;
  localparam int unsigned REG_AR_BASE  = LAG_MAX;
  localparam int unsigned STALL_LIMIT  = 2000;
  localparam int unsigned HOLD_CYCLES  = 200;
  localparam int unsigned DRAIN_CYCLES = 8;

  localparam coef_t COEF_MAX = 18'sh1FFFF;
  localparam coef_t COEF_MIN = -18'sh20000;
  localparam coef_t COEF_ONE = 18'sh10000;

  typedef enum int {COEF_FULL, COEF_MILD, COEF_EDGE} coef_mode_e;

  typedef struct packed {
    sample_t sample_out;
    logic    saturated;
  } filt_result_t;

  logic              clk_i = 1'b0;
  logic              rst_ni;
  logic              s_axis_tvalid;
  logic              s_axis_tready;
  logic [15:0]       s_axis_tdata;   // [15:0] sample_in
  logic [0:0]        s_axis_tuser;   // [0] restart
  logic              m_axis_tvalid;
  logic              m_axis_tready;
  logic [15:0]       m_axis_tdata;   // [15:0] sample_out
  logic [0:0]        m_axis_tuser;   // [0] saturated
  logic              psel;
  logic              penable;
  logic              pwrite;
  logic [APB_AW-1:0] paddr;
  logic [APB_DW-1:0] pwdata;
  logic [APB_DW-1:0] prdata;
  logic              pready;

  // Local copy of the filter: coefficients and both sample histories.
  coef_t   ma_coef  [LAG_MAX];
  coef_t   ar_coef  [LAG_MAX];
  sample_t in_hist  [LAG_MAX];
  sample_t out_hist [LAG_MAX];

  filt_result_t predicted_q[$];
  int unsigned  err_count   = 0;
  int unsigned  quiet_cycles = 0;
  bit           idle_en     = 1'b1;
  bit           hold_req    = 1'b0;

  arma_iir_filter_unit uut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser),
    .psel          (psel),
    .penable       (penable),
    .pwrite        (pwrite),
    .paddr         (paddr),
    .pwdata        (pwdata),
    .prdata        (prdata),
    .pready        (pready)
  );

  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  // One step of the filter: Q3.31 products summed exactly, rounded half up
  // to Q1.15, saturated, and the clipped value fed back into the history.
  function automatic filt_result_t predict_output(input sample_t x, input logic restart);
    longint       acc;
    longint       rnd;
    filt_result_t res;
    if (restart) begin
      for (int k = 0; k < LAG_MAX; k++) begin
        in_hist[k]  = '0;
        out_hist[k] = '0;
      end
    end
    acc = 0;
    for (int k = 0; k < MA_N; k++) acc += longint'(ma_coef[k]) * longint'(in_hist[k]);
    for (int k = 0; k < AR_N; k++) acc -= longint'(ar_coef[k]) * longint'(out_hist[k]);
    rnd = (acc + 32768) >>> FRAC_SH;
    res.saturated = 1'b0;
    if (rnd > 32767) begin
      rnd = 32767;
      res.saturated = 1'b1;
    end else if (rnd < -32768) begin
      rnd = -32768;
      res.saturated = 1'b1;
    end
    res.sample_out = sample_t'(rnd);
    for (int k = LAG_MAX - 1; k > 0; k--) begin
      in_hist[k]  = in_hist[k-1];
      out_hist[k] = out_hist[k-1];
    end
    in_hist[0]  = x;
    out_hist[0] = res.sample_out;
    return res;
  endfunction

  function automatic sample_t rand_sample();
    case ($urandom_range(0, 15))
      0:       return 16'sh7FFF;
      1:       return -16'sh8000;
      2:       return '0;
      3:       return -16'sh1;
      default: return sample_t'($urandom);
    endcase
  endfunction

  function automatic coef_t rand_coef(input coef_mode_e mode);
    case (mode)
      COEF_MILD: return coef_t'(int'($urandom_range(0, 16384)) - 8192);
      COEF_EDGE: begin
        case ($urandom_range(0, 3))
          0:       return COEF_MAX;
          1:       return COEF_MIN;
          2:       return COEF_ONE;
          default: return '0;
        endcase
      end
      default:   return coef_t'($urandom);
    endcase
  endfunction

  // APB write: setup, access, then the bus is released before the task returns so
  // that back-to-back writes never assign psel twice in the same step.
  task automatic write_reg(input int unsigned idx, input coef_t val);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= APB_AW'(4 * idx);
    pwdata  <= {{(APB_DW-COEF_W){val[COEF_W-1]}}, val};
    @(posedge clk_i);
    penable <= 1'b1;
    @(posedge clk_i);
    while (!pready) @(posedge clk_i);
    if (idx < REG_AR_BASE) ma_coef[idx - REG_MA_BASE] = val;
    else                   ar_coef[idx - REG_AR_BASE] = val;
    psel    <= 1'b0;
    penable <= 1'b0;
    @(posedge clk_i);
  endtask

  task automatic set_random_coefs(input coef_mode_e mode);
    for (int unsigned i = 0; i < NUM_REGS; i++) write_reg(i, rand_coef(mode));
  endtask

  // Offers one sample and returns at the edge where it is accepted; the
  // prediction is queued at that edge.
  task automatic send_sample(input sample_t x, input logic restart);
    filt_result_t res;
    if (idle_en && ($urandom_range(0, 9) == 0)) begin
      s_axis_tvalid <= 1'b0;
      repeat ($urandom_range(1, 17)) @(posedge clk_i);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= x;
    s_axis_tuser  <= restart;
    @(posedge clk_i);
    while (!s_axis_tready) @(posedge clk_i);
    res = predict_output(x, restart);
    predicted_q = {predicted_q, res};
  endtask

  // Stops offering and waits until every predicted output has come out.
  task automatic drain_stream();
    s_axis_tvalid <= 1'b0;
    while (predicted_q.size() != 0) @(posedge clk_i);
    repeat (DRAIN_CYCLES) @(posedge clk_i);
  endtask

  // Coefficients at their reset value of zero: every output is zero.
  task automatic test_reset_state();
    send_sample(16'sh7FFF, 1'b0);
    send_sample(-16'sh8000, 1'b1);
    send_sample('0, 1'b0);
    send_sample(16'sh1, 1'b0);
    drain_stream();
  endtask

  // A lag-one gain of 2^-15 puts the sum exactly on a half, so ties go up
  // for both signs.
  task automatic test_rounding_ties();
    write_reg(REG_MA_BASE, 18'sd2);
    send_sample(16'sd16384, 1'b1);
    send_sample(-16'sd16384, 1'b0);
    send_sample(16'sd16383, 1'b0);
    send_sample(-16'sd16385, 1'b0);
    send_sample('0, 1'b0);
    drain_stream();
  endtask

  // Extreme coefficients drive the output into both rails; a restart in the
  // middle must bring the output back to zero.
  task automatic test_saturation_restart();
    for (int unsigned i = 0; i < LAG_MAX; i++) begin
      write_reg(REG_MA_BASE + i, COEF_MAX);
      write_reg(REG_AR_BASE + i, COEF_MIN);
    end
    send_sample(16'sh7FFF, 1'b0);
    send_sample(16'sh7FFF, 1'b0);
    send_sample(-16'sh8000, 1'b0);
    send_sample(16'sh7FFF, 1'b0);
    send_sample(16'sd100, 1'b1);
    drain_stream();
    for (int unsigned i = 0; i < LAG_MAX; i++) begin
      write_reg(REG_MA_BASE + i, COEF_MIN);
      write_reg(REG_AR_BASE + i, COEF_MAX);
    end
    send_sample(-16'sh8000, 1'b0);
    send_sample(-16'sh8000, 1'b0);
    send_sample(16'sh7FFF, 1'b0);
    send_sample(-16'sh1, 1'b1);
    send_sample(16'sh7FFF, 1'b0);
    drain_stream();
  endtask

  // Several coefficient sets, each followed by a run of random samples with
  // an occasional restart.
  task automatic test_random_settings();
    for (int phase = 0; phase < 6; phase++) begin
      set_random_coefs(coef_mode_e'(phase % 3));
      repeat (150) send_sample(rand_sample(), $urandom_range(0, 31) == 0);
      drain_stream();
    end
  endtask

  // The receiver holds off for a long stretch while samples keep coming, so
  // the internal queue fills and the input stalls.
  task automatic test_backpressure();
    idle_en  = 1'b0;
    set_random_coefs(COEF_MILD);
    hold_req = 1'b1;
    repeat (40) send_sample(rand_sample(), $urandom_range(0, 31) == 0);
    drain_stream();
  endtask

  // Full-rate stream with no idling on either side.
  task automatic test_steady_stream();
    idle_en = 1'b0;
    set_random_coefs(COEF_FULL);
    repeat (200) send_sample(rand_sample(), $urandom_range(0, 31) == 0);
    drain_stream();
  endtask

  initial begin
    for (int k = 0; k < LAG_MAX; k++) begin
      ma_coef[k]  = '0;
      ar_coef[k]  = '0;
      in_hist[k]  = '0;
      out_hist[k] = '0;
    end
    rst_ni        = 1'b0;
    s_axis_tvalid = 1'b0;
    s_axis_tdata  = '0;
    s_axis_tuser  = '0;
    psel          = 1'b0;
    penable       = 1'b0;
    pwrite        = 1'b0;
    paddr         = '0;
    pwdata        = '0;
    repeat (6) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    test_reset_state();
    test_rounding_ties();
    test_saturation_restart();
    test_random_settings();
    test_backpressure();
    test_steady_stream();
    if (err_count == 0) begin
      $display("arma_iir_filter_unit: match");
    end else begin
      $display("arma_iir_filter_unit: mismatch");
    end
    $finish;
  end

  // Receiver: random stall bursts, plus one long hold-off on request.
  initial begin
    m_axis_tready = 1'b0;
    forever begin
      @(posedge clk_i);
      if (hold_req) begin
        hold_req = 1'b0;
        m_axis_tready <= 1'b0;
        repeat (HOLD_CYCLES) @(posedge clk_i);
      end else if (idle_en && ($urandom_range(0, 7) == 0)) begin
        m_axis_tready <= 1'b0;
        repeat ($urandom_range(1, 17)) @(posedge clk_i);
      end else begin
        m_axis_tready <= 1'b1;
      end
    end
  end

  // Output check against the oldest prediction.
  always @(posedge clk_i) begin
    filt_result_t want;
    if (rst_ni && m_axis_tvalid && m_axis_tready) begin
      if (predicted_q.size() == 0) begin
        $display("%0t: unexpected output sample %0d, saturated %0b", $time,
                 $signed(m_axis_tdata), m_axis_tuser[0]);
        err_count++;
      end else begin
        want = predicted_q.pop_front();
        if (m_axis_tdata !== want.sample_out) begin
          $display("%0t: sample_out expected %0d, got %0d", $time,
                   $signed(want.sample_out), $signed(m_axis_tdata));
          err_count++;
        end
        if (m_axis_tuser[0] !== want.saturated) begin
          $display("%0t: saturated expected %0b, got %0b", $time,
                   want.saturated, m_axis_tuser[0]);
          err_count++;
        end
      end
    end
  end

  // Watchdog: ends the run when no item and no register write has moved
  // for too many cycles in a row.
  always @(posedge clk_i) begin
    if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready) ||
        (psel && penable && pready)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= STALL_LIMIT) begin
      $display("arma_iir_filter_unit: mismatch");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

endmodule
